// ===== design/srls_pkg.sv =====
// shared types and constants for the scalar rls gain estimator
// no dependencies; used by the arithmetic unit and the top level
package srls_pkg;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } arith_rsp_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_X    = 10'b00_0000_0010,
    S_XP   = 10'b00_0000_0100,
    S_DEN  = 10'b00_0000_1000,
    S_K    = 10'b00_0001_0000,
    S_E    = 10'b00_0010_0000,
    S_WN   = 10'b00_0100_0000,
    S_S    = 10'b00_1000_0000,
    S_PN   = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } seq_state_t;

  localparam logic [1:0] FUNC_THRU    = 2'd0;
  localparam logic [1:0] FUNC_RESP    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [2:0] STAT_UPDATED   = 3'd0;
  localparam logic [2:0] STAT_SKIPPED   = 3'd1;
  localparam logic [2:0] STAT_RESTARTED = 3'd2;
  localparam logic [2:0] STAT_SATURATED = 3'd3;
  localparam logic [2:0] STAT_ZERO_CAP  = 3'd4;

  localparam logic [1:0] REG_LAMBDA    = 2'd0;
  localparam logic [1:0] REG_INIT_GAIN = 2'd1;
  localparam logic [1:0] REG_INIT_COV  = 2'd2;

  localparam logic [16:0] LAMBDA_RESET = 17'd13107;
  localparam logic [30:0] COV_RESET    = 31'd65536000;

endpackage

// ===== design/srls_in_if.sv =====
// input channel of the rls estimator: one sample word per handshake
// depends on nothing
interface srls_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [30:0]        capacity;
  logic signed [31:0] measurement;
  logic [30:0]        queue_length;

  modport source(output valid, func, capacity, measurement, queue_length, input ready);
  modport sink(input valid, func, capacity, measurement, queue_length, output ready);
endinterface

// ===== design/srls_out_if.sv =====
// output channel of the rls estimator: one result word per handshake
// depends on nothing
interface srls_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gain_out;
  logic [30:0]        covariance_out;
  logic [2:0]         status;

  modport source(output valid, gain_out, covariance_out, status, input ready);
  modport sink(input valid, gain_out, covariance_out, status, output ready);
endinterface

// ===== design/srls_arith.sv =====
// bit-serial fixed point multiply and divide with saturation
// depends on srls_pkg
module srls_arith #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int OW = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  srls_pkg::arith_req_t    req,
  input  logic signed [OW-1:0]    a,
  input  logic signed [OW-1:0]    b,
  output srls_pkg::arith_rsp_t    rsp,
  output logic signed [OW-1:0]    res
);

  localparam int MW = 2 * OW;
  localparam int CW = $clog2(OW + F + 1);
  localparam logic signed [W-1:0] WMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN_W = {1'b1, {(W-1){1'b0}}};

  logic                busy;
  srls_pkg::arith_op_t op_q;
  logic                neg;
  logic                aneg;
  logic                anz;
  logic                zdiv;
  logic [CW-1:0]       cnt;
  logic [OW-1:0]       ma;
  logic [OW-1:0]       mb;
  logic [MW-1:0]       acc;
  logic [OW:0]         rem;

  logic [OW-1:0]       a_mag;
  logic [OW-1:0]       b_mag;
  logic [OW:0]         sum;
  logic [OW:0]         r2;
  logic                ge;
  logic [MW-1:0]       big;
  logic [MW-1:0]       top;
  logic                ovf;
  logic [W-1:0]        mag;
  logic signed [W-1:0] res_w;

  assign a_mag = a[OW-1] ? (~a + 1'b1) : a;
  assign b_mag = b[OW-1] ? (~b + 1'b1) : b;

  // one partial product or one quotient bit per cycle
  assign sum = {1'b0, acc[MW-1:OW]} + (mb[0] ? {1'b0, ma} : '0);
  assign r2  = {rem[OW-1:0], acc[OW+F-1]};
  assign ge  = r2 >= {1'b0, mb};

  always_comb begin
    big   = (op_q == srls_pkg::OP_MUL) ? (acc >> F) : MW'(acc[OW+F-1:0]);
    top   = big >> (W - 1);
    ovf   = (top != '0) && !(neg && top == MW'(1) && big[W-2:0] == '0);
    mag   = big[W-1:0];
    res_w = neg ? -$signed(mag) : $signed(mag);
    if (zdiv) begin
      res_w = !anz ? '0 : (aneg ? WMIN_W : WMAX_W);
    end else if (ovf) begin
      res_w = neg ? WMIN_W : WMAX_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      rsp.sat  <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy <= 1'b1;
          op_q <= req.op;
          neg  <= a[OW-1] ^ b[OW-1];
          aneg <= a[OW-1];
          anz  <= (a != '0);
          zdiv <= (req.op == srls_pkg::OP_DIV) && (b == '0);
          ma   <= a_mag;
          mb   <= b_mag;
          rem  <= '0;
          if (req.op == srls_pkg::OP_MUL) begin
            acc <= '0;
            cnt <= CW'(OW);
          end else begin
            acc <= MW'(a_mag) << F;
            cnt <= CW'(OW + F);
          end
        end
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (op_q == srls_pkg::OP_MUL) begin
          acc <= {sum, acc[OW-1:1]};
          mb  <= mb >> 1;
        end else begin
          rem <= ge ? (r2 - {1'b0, mb}) : r2;
          acc <= {acc[MW-2:0], ge};
        end
      end else begin
        busy     <= 1'b0;
        rsp.done <= 1'b1;
        rsp.sat  <= zdiv | ovf;
        res      <= OW'(res_w);
      end
    end
  end

endmodule

// ===== design/scalar_rls_gain_estimator_top.sv =====
// scalar rls gain estimator with forgetting factor, top level
// depends on srls_pkg, srls_in_if, srls_out_if and srls_arith
//
// usage: a sample word enters on the sample channel (valid/ready) and one
// result word leaves on the result channel for every sample. configuration
// is written over the apb port: lambda at 0x0, initial gain at 0x4,
// initial covariance at 0x8; pready is tied high and reads return the value.
// a restart or skipped sample goes to the output state when it is taken and
// loads its result word from there once the output register is free, after
// which the next sample can be taken. updates run on one shared bit-serial
// unit: a multiply or divide goes through launch, one bit per cycle, done and
// hand-back. a throughput update is five multiplies and two divides; a
// response time update adds one divide. one sample is worked on at a time,
// so a new sample is taken only after the result loads and the sequencer
// returns to idle.
// the result sits in an output register, so the next sample is taken while
// a stalled result waits; a further finished result holds until it drains.
// reset (rst, synchronous) clears gain to 0, covariance to 1000.0 and the
// registers to their defaults.
module scalar_rls_gain_estimator_top #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  srls_in_if.sink     sample,
  srls_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int OW  = (W > F + 2) ? W : F + 2;
  localparam int XW  = ((OW > 33) ? OW : 33) + 2;
  localparam int LSH = (F >= 16) ? F - 16 : 0;
  localparam int RSH = (F < 16) ? 16 - F : 0;

  localparam logic signed [XW-1:0] WMAX_X  = {{(XW+1-W){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] WMIN_X  = ~WMAX_X;
  localparam logic signed [XW-1:0] ONE_X   = XW'(1) << F;
  localparam logic signed [XW-1:0] COV0_X  = XW'(1000) << F;
  localparam logic signed [XW-1:0] G_MAX_X = XW'(33'sh0_7FFF_FFFF);
  localparam logic signed [XW-1:0] G_MIN_X = ~G_MAX_X;

  function automatic logic signed [OW-1:0] clip(input logic signed [XW-1:0] v);
    if (v > WMAX_X) return OW'(WMAX_X);
    if (v < WMIN_X) return OW'(WMIN_X);
    return OW'(v);
  endfunction

  function automatic logic ovf(input logic signed [XW-1:0] v);
    return (v > WMAX_X) || (v < WMIN_X);
  endfunction

  // configuration
  logic [16:0]        lambda;
  logic signed [31:0] init_gain;
  logic [30:0]        init_cov;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda    <= srls_pkg::LAMBDA_RESET;
      init_gain <= '0;
      init_cov  <= srls_pkg::COV_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        srls_pkg::REG_LAMBDA:    lambda    <= pwdata[16:0];
        srls_pkg::REG_INIT_GAIN: init_gain <= $signed(pwdata);
        srls_pkg::REG_INIT_COV:  init_cov  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      srls_pkg::REG_LAMBDA:    prdata = {15'b0, lambda};
      srls_pkg::REG_INIT_GAIN: prdata = init_gain;
      srls_pkg::REG_INIT_COV:  prdata = {1'b0, init_cov};
      default:                 prdata = '0;
    endcase
  end

  // sequencer state
  srls_pkg::seq_state_t state;
  logic                 launched;
  logic                 sat;
  logic                 upd;
  logic [2:0]           stat_q;
  logic signed [OW-1:0] w;
  logic signed [OW-1:0] p;
  logic signed [OW-1:0] x;
  logic signed [OW-1:0] d;
  logic signed [OW-1:0] xp;
  logic signed [OW-1:0] den;
  logic signed [OW-1:0] k;
  logic signed [OW-1:0] e;
  logic signed [OW-1:0] s;

  logic                 out_valid;
  logic signed [31:0]   gain_q;
  logic [30:0]          cov_q;
  logic [2:0]           status_q;

  srls_pkg::arith_req_t areq;
  srls_pkg::arith_rsp_t arsp;
  logic signed [OW-1:0] aa;
  logic signed [OW-1:0] ab;
  logic signed [OW-1:0] ares;

  logic [OW-1:0]        lam_u;
  logic signed [OW-1:0] lam_s;
  logic signed [XW-1:0] cap_x;
  logic signed [XW-1:0] meas_x;
  logic signed [XW-1:0] q_x;
  logic signed [OW-1:0] cap_c;
  logic signed [OW-1:0] meas_c;
  logic signed [OW-1:0] q_c;
  logic signed [XW-1:0] q1_x;
  logic                 in_sat;
  logic                 in_acc;
  logic                 op_state;
  logic signed [XW-1:0] den_x;
  logic signed [XW-1:0] e_x;
  logic signed [XW-1:0] wn_x;
  logic signed [XW-1:0] s_x;
  logic signed [XW-1:0] gx;
  logic signed [XW-1:0] px;
  logic signed [31:0]   gain_next;
  logic [30:0]          cov_next;
  logic                 out_sat;
  logic                 out_load;

  assign lam_u = (OW'(lambda) << LSH) >> RSH;
  assign lam_s = $signed(lam_u);

  assign cap_x  = XW'($signed({1'b0, sample.capacity}));
  assign meas_x = XW'(sample.measurement);
  assign q_x    = XW'($signed({1'b0, sample.queue_length}));
  assign cap_c  = clip(cap_x);
  assign meas_c = clip(meas_x);
  assign q_c    = clip(q_x);
  assign q1_x   = XW'(q_c) + ONE_X;
  assign in_sat = ovf(cap_x) | ovf(meas_x) | ovf(q_x);

  assign sample.ready = (state == srls_pkg::S_IDLE);
  assign in_acc       = sample.valid & sample.ready;

  assign op_state = (state != srls_pkg::S_IDLE) && (state != srls_pkg::S_OUT);

  always_comb begin
    areq.start = op_state && !launched;
    areq.op    = srls_pkg::OP_MUL;
    aa         = '0;
    ab         = '0;
    unique case (state)
      srls_pkg::S_X:   begin areq.op = srls_pkg::OP_DIV; aa = x;  ab = den;   end
      srls_pkg::S_XP:  begin aa = x;  ab = p;  end
      srls_pkg::S_DEN: begin aa = x;  ab = xp; end
      srls_pkg::S_K:   begin areq.op = srls_pkg::OP_DIV; aa = xp; ab = den;   end
      srls_pkg::S_E:   begin aa = x;  ab = w;  end
      srls_pkg::S_WN:  begin aa = k;  ab = e;  end
      srls_pkg::S_S:   begin aa = k;  ab = xp; end
      srls_pkg::S_PN:  begin areq.op = srls_pkg::OP_DIV; aa = s;  ab = lam_s; end
      default: ;
    endcase
  end

  srls_arith #(
    .W  (W),
    .F  (F),
    .OW (OW)
  ) u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .a   (aa),
    .b   (ab),
    .rsp (arsp),
    .res (ares)
  );

  assign den_x = XW'(lam_s) + XW'(ares);
  assign e_x   = XW'(d) - XW'(ares);
  assign wn_x  = XW'(w) + XW'(ares);
  assign s_x   = XW'(p) - XW'(ares);

  // final word clamps to the 32 bit gain and 31 bit covariance ranges
  always_comb begin
    gx      = XW'(w);
    px      = XW'(p);
    out_sat = 1'b0;
    if (gx > G_MAX_X) begin
      gain_next = 32'sh7FFF_FFFF;
      out_sat   = 1'b1;
    end else if (gx < G_MIN_X) begin
      gain_next = {1'b1, 31'b0};
      out_sat   = 1'b1;
    end else begin
      gain_next = gx[31:0];
    end
    if (px > G_MAX_X) begin
      cov_next = {31{1'b1}};
      out_sat  = 1'b1;
    end else begin
      cov_next = px[30:0];
    end
  end

  assign out_load = (state == srls_pkg::S_OUT) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srls_pkg::S_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      w         <= '0;
      p         <= clip(COV0_X);
      sat       <= 1'b0;
      upd       <= 1'b0;
      stat_q    <= srls_pkg::STAT_SKIPPED;
    end else begin
      if (out_valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (areq.start) begin
        launched <= 1'b1;
      end
      unique case (state)
        srls_pkg::S_IDLE: begin
          if (in_acc) begin
            d <= meas_c;
            unique case (sample.func)
              srls_pkg::FUNC_THRU: begin
                sat <= in_sat;
                if (meas_c != '0) begin
                  x      <= cap_c;
                  upd    <= 1'b1;
                  stat_q <= srls_pkg::STAT_UPDATED;
                  state  <= srls_pkg::S_XP;
                end else begin
                  upd    <= 1'b0;
                  stat_q <= srls_pkg::STAT_SKIPPED;
                  state  <= srls_pkg::S_OUT;
                end
              end
              srls_pkg::FUNC_RESP: begin
                if (cap_c == '0) begin
                  sat    <= in_sat;
                  upd    <= 1'b0;
                  stat_q <= srls_pkg::STAT_ZERO_CAP;
                  state  <= srls_pkg::S_OUT;
                end else begin
                  // regressor is (queue + 1.0) / capacity
                  x      <= clip(q1_x);
                  den    <= cap_c;
                  sat    <= in_sat | ovf(q1_x);
                  upd    <= 1'b1;
                  stat_q <= srls_pkg::STAT_UPDATED;
                  state  <= srls_pkg::S_X;
                end
              end
              srls_pkg::FUNC_RESTART: begin
                w      <= clip(XW'(init_gain));
                p      <= clip(XW'($signed({1'b0, init_cov})));
                sat    <= in_sat;
                upd    <= 1'b0;
                stat_q <= srls_pkg::STAT_RESTARTED;
                state  <= srls_pkg::S_OUT;
              end
              default: begin
                sat    <= in_sat;
                upd    <= 1'b0;
                stat_q <= srls_pkg::STAT_SKIPPED;
                state  <= srls_pkg::S_OUT;
              end
            endcase
          end
        end
        srls_pkg::S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            gain_q    <= gain_next;
            cov_q     <= cov_next;
            status_q  <= (upd && (sat || out_sat)) ? srls_pkg::STAT_SATURATED : stat_q;
            state     <= srls_pkg::S_IDLE;
          end
        end
        default: begin
          if (arsp.done) begin
            launched <= 1'b0;
            unique case (state)
              srls_pkg::S_X:   begin
                x     <= ares;
                sat   <= sat | arsp.sat;
                state <= srls_pkg::S_XP;
              end
              srls_pkg::S_XP:  begin
                xp    <= ares;
                sat   <= sat | arsp.sat;
                state <= srls_pkg::S_DEN;
              end
              srls_pkg::S_DEN: begin
                den   <= clip(den_x);
                sat   <= sat | arsp.sat | ovf(den_x);
                state <= srls_pkg::S_K;
              end
              srls_pkg::S_K:   begin
                k     <= ares;
                sat   <= sat | arsp.sat;
                state <= srls_pkg::S_E;
              end
              srls_pkg::S_E:   begin
                e     <= clip(e_x);
                sat   <= sat | arsp.sat | ovf(e_x);
                state <= srls_pkg::S_WN;
              end
              srls_pkg::S_WN:  begin
                w     <= clip(wn_x);
                sat   <= sat | arsp.sat | ovf(wn_x);
                state <= srls_pkg::S_S;
              end
              srls_pkg::S_S:   begin
                s     <= clip(s_x);
                sat   <= sat | arsp.sat | ovf(s_x);
                state <= srls_pkg::S_PN;
              end
              default: begin
                // negative covariance from rounding clamps to zero
                p     <= ares[OW-1] ? '0 : ares;
                sat   <= sat | arsp.sat;
                state <= srls_pkg::S_OUT;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.gain_out       = gain_q;
  assign result.covariance_out = cov_q;
  assign result.status         = status_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != srls_pkg::S_IDLE)
    else $error("sequencer stayed idle after taking a sample");

  a_cov_nonneg: assert property (@(posedge clk) disable iff (rst)
    !p[OW-1])
    else $error("covariance went negative");

  a_done_when_launched: assert property (@(posedge clk) disable iff (rst)
    arsp.done |-> launched && op_state)
    else $error("arithmetic result without a pending operation");

  a_load_clears_state: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == srls_pkg::S_IDLE)
    else $error("result word not presented after load");
`endif

endmodule
